FILE: rtl/rme_pkg.sv
// Shared constants, types and register indexes for the modular exponentiation block.
// Depends on nothing; every other file in rtl/ imports it.
package rme_pkg;

  // Operand width used for message, exponent and modulus (8 to 32).
  localparam int WORD_BITS  = 32;
  // Port widths fixed by the interface.
  localparam int MSG_W      = 32;
  localparam int RES_W      = 32;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;

  // The remainder unit retires this many product bits per cycle.
  localparam int STEP_BITS  = 2;
  localparam int PROD_W     = 2 * WORD_BITS;
  localparam int STEPS      = PROD_W / STEP_BITS;
  localparam int CNT_W      = $clog2(STEPS);

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_PUBLIC_EXP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRIVATE_EXP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS     = 2'd2;

  // Command codes.
  localparam logic CMD_ENCRYPT = 1'b0;
  localparam logic CMD_DECRYPT = 1'b1;

  typedef logic [WORD_BITS-1:0] word_t;

  // Request to the shared multiply-reduce unit.
  typedef struct packed {
    logic  start;
    word_t a;
    word_t b;
    word_t n;
  } mm_req_t;

  // Response from the shared multiply-reduce unit.
  typedef struct packed {
    logic  done;
    word_t p;
  } mm_rsp_t;

endpackage

FILE: rtl/rme_in_if.sv
// Input channel: command and message words with a valid/ready handshake.
// Depends on rme_pkg.
interface rme_in_if;
  import rme_pkg::*;

  logic             valid;
  logic             ready;
  logic             command;
  logic [MSG_W-1:0] message;

  modport source (output valid, output command, output message, input ready);
  modport sink   (input valid, input command, input message, output ready);
endinterface

FILE: rtl/rme_out_if.sv
// Result channel: result words with a valid/ready handshake.
// Depends on rme_pkg.
interface rme_out_if;
  import rme_pkg::*;

  logic             valid;
  logic             ready;
  logic [RES_W-1:0] result;

  modport source (output valid, output result, input ready);
  modport sink   (input valid, input result, output ready);
endinterface

FILE: rtl/rme_modmul.sv
// Shared multiply-reduce unit: p = (a * b) mod n with a restoring bit-serial remainder.
// Depends on rme_pkg. The modulus must be nonzero when a request starts.
module rme_modmul (
  input  logic             clk,
  input  logic             rst_n,
  input  rme_pkg::mm_req_t req,
  output rme_pkg::mm_rsp_t rsp
);
  import rme_pkg::*;

  localparam logic [CNT_W-1:0] LAST = CNT_W'(STEPS - 1);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [PROD_W-1:0] prod_r;
  word_t             n_r;
  word_t             rem_r;
  word_t             res_r;
  logic [PROD_W-1:0] mul_full;
  word_t             rem_step;
  logic [WORD_BITS:0] trial;

  // Exact product of the two operands, taken straight from the request registers.
  assign mul_full = {{WORD_BITS{1'b0}}, req.a} * {{WORD_BITS{1'b0}}, req.b};

  // Shift the top product bits into the remainder, subtracting n when it fits.
  always_comb begin
    rem_step = rem_r;
    trial    = '0;
    for (int k = 0; k < STEP_BITS; k++) begin
      trial = {rem_step, prod_r[PROD_W-1-k]};
      if (trial >= {1'b0, n_r}) begin
        trial = trial - {1'b0, n_r};
      end
      rem_step = trial[WORD_BITS-1:0];
    end
  end

  // Control: idle, then one pass over the product, then a one-cycle done pulse.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (req.start && !busy_r) begin
      prod_r <= mul_full;
      n_r    <= req.n;
      rem_r  <= '0;
    end else if (busy_r) begin
      prod_r <= prod_r << STEP_BITS;
      rem_r  <= rem_step;
      if (cnt_r == LAST) begin
        res_r <= rem_step;
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.p    = res_r;

  // A new request never arrives while a reduction is running.
  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r)
    else $error("modmul started while busy");

  // The done pulse follows the last reduction step.
  a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && cnt_r == LAST |=> done_r && !busy_r)
    else $error("modmul did not finish after the last step");

  // The reduced value always lies below the modulus.
  a_res_below_n: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> res_r < n_r)
    else $error("modmul result not reduced");

endmodule

FILE: rtl/rme_ctrl.sv
// Sequencer for right-to-left square-and-multiply over the shared multiply-reduce unit,
// with the output register. Depends on rme_pkg, rme_in_if and rme_out_if.
module rme_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  rme_in_if.sink                          in_ch,
  rme_out_if.source                       out_ch,
  input  logic [rme_pkg::CFG_DATA_W-1:0]  public_exponent,
  input  logic [rme_pkg::CFG_DATA_W-1:0]  private_exponent,
  input  logic [rme_pkg::CFG_DATA_W-1:0]  modulus,
  output rme_pkg::mm_req_t                mm_req,
  input  rme_pkg::mm_rsp_t                mm_rsp
);
  import rme_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_BASE = 5'b00010,
    S_MUL  = 5'b00100,
    S_SQR  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t           state_r, state_nxt;
  word_t            exp_r, exp_nxt;
  word_t            acc_r, acc_nxt;
  word_t            b_r, b_nxt;
  word_t            n_r, n_nxt;
  logic             start_r, start_nxt;
  word_t            opa_r, opa_nxt;
  word_t            opb_r, opb_nxt;
  logic             out_valid_r;
  logic [RES_W-1:0] out_result_r;
  word_t            in_msg;
  word_t            in_exp;
  word_t            in_n;
  word_t            exp_shift;
  logic             out_free;

  assign in_msg    = in_ch.message[WORD_BITS-1:0];
  assign in_exp    = (in_ch.command == CMD_DECRYPT) ? private_exponent[WORD_BITS-1:0]
                                                    : public_exponent[WORD_BITS-1:0];
  assign in_n      = modulus[WORD_BITS-1:0];
  assign exp_shift = exp_r >> 1;
  assign out_free  = !out_valid_r || out_ch.ready;

  assign in_ch.ready = (state_r == S_IDLE);

  // Next-step decisions of the exponent scan.
  always_comb begin
    state_nxt = state_r;
    exp_nxt   = exp_r;
    acc_nxt   = acc_r;
    b_nxt     = b_r;
    n_nxt     = n_r;
    start_nxt = 1'b0;
    opa_nxt   = opa_r;
    opb_nxt   = opb_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          if (in_msg == '0 || in_n == '0) begin
            acc_nxt   = '0;
            state_nxt = S_DONE;
          end else begin
            // Reduce the message first: message * 1 mod n.
            exp_nxt   = in_exp;
            n_nxt     = in_n;
            acc_nxt   = (in_n == word_t'(1)) ? '0 : word_t'(1);
            start_nxt = 1'b1;
            opa_nxt   = in_msg;
            opb_nxt   = word_t'(1);
            state_nxt = S_BASE;
          end
        end
      end
      S_BASE: begin
        if (mm_rsp.done) begin
          b_nxt = mm_rsp.p;
          if (exp_r == '0) begin
            state_nxt = S_DONE;
          end else if (exp_r[0]) begin
            start_nxt = 1'b1;
            opa_nxt   = acc_r;
            opb_nxt   = mm_rsp.p;
            state_nxt = S_MUL;
          end else begin
            start_nxt = 1'b1;
            opa_nxt   = mm_rsp.p;
            opb_nxt   = mm_rsp.p;
            state_nxt = S_SQR;
          end
        end
      end
      S_MUL: begin
        if (mm_rsp.done) begin
          acc_nxt = mm_rsp.p;
          // No higher exponent bits: the square is not needed.
          if (exp_shift == '0) begin
            state_nxt = S_DONE;
          end else begin
            start_nxt = 1'b1;
            opa_nxt   = b_r;
            opb_nxt   = b_r;
            state_nxt = S_SQR;
          end
        end
      end
      S_SQR: begin
        if (mm_rsp.done) begin
          b_nxt   = mm_rsp.p;
          exp_nxt = exp_shift;
          if (exp_shift == '0) begin
            state_nxt = S_DONE;
          end else if (exp_shift[0]) begin
            start_nxt = 1'b1;
            opa_nxt   = acc_r;
            opb_nxt   = mm_rsp.p;
            state_nxt = S_MUL;
          end else begin
            start_nxt = 1'b1;
            opa_nxt   = mm_rsp.p;
            opb_nxt   = mm_rsp.p;
            state_nxt = S_SQR;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      start_r <= start_nxt;
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    exp_r <= exp_nxt;
    acc_r <= acc_nxt;
    b_r   <= b_nxt;
    n_r   <= n_nxt;
    opa_r <= opa_nxt;
    opb_r <= opb_nxt;
    if (state_r == S_DONE && out_free) begin
      out_result_r <= RES_W'(acc_r);
    end
  end

  assign mm_req.start  = start_r;
  assign mm_req.a      = opa_r;
  assign mm_req.b      = opb_r;
  assign mm_req.n      = n_r;
  assign out_ch.valid  = out_valid_r;
  assign out_ch.result = out_result_r;

  // The unit answers only while the sequencer is waiting on it.
  a_done_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    mm_rsp.done |-> (state_r == S_BASE || state_r == S_MUL || state_r == S_SQR))
    else $error("multiply-reduce done outside a wait state");

  // A request is issued only on leaving idle or on a response.
  a_start_source: assert property (@(posedge clk) disable iff (!rst_n)
    start_r |-> $past(state_r == S_IDLE || mm_rsp.done))
    else $error("multiply-reduce started without cause");

  // Finishing an item loads the output register and frees the input side.
  a_finish_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE && out_free |=> out_valid_r && state_r == S_IDLE)
    else $error("finished word not presented");

endmodule

FILE: rtl/rsa_modular_exponentiation_top.sv
// Top level of the modular exponentiation block: configuration registers and instances.
// Depends on rme_pkg, rme_in_if, rme_out_if, rme_modmul and rme_ctrl.
//
// Each input word (command, message) yields one result word, message raised to the public
// (encrypt) or private (decrypt) exponent modulo the modulus, by right-to-left binary
// square-and-multiply. All work runs through one shared multiply-reduce unit, which forms
// the exact 2*WORD_BITS product and reduces it two bits per cycle. An item costs one
// multiplication to reduce the message plus one square per exponent bit below the top set
// bit and one multiply per set bit: at most 2*WORD_BITS multiplications, far fewer for
// short exponents such as 65537. A zero message or zero modulus skips the unit and goes
// straight to the done state. The input is not ready while an item is in progress; a
// finished result sits in an output register, so the next word is taken while it waits.
// Configuration is written with cfg_we, cfg_index and cfg_wdata; the user must write it
// only while the block is idle, which the block itself does not enforce; index 0 is the
// public exponent, 1 the private exponent, 2 the modulus, 3 is ignored.
module rsa_modular_exponentiation_top (
  input  logic                           clk,
  input  logic                           rst_n,
  rme_in_if.sink                         in_ch,
  rme_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [rme_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rme_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import rme_pkg::*;

  logic [CFG_DATA_W-1:0] public_exponent_r;
  logic [CFG_DATA_W-1:0] private_exponent_r;
  logic [CFG_DATA_W-1:0] modulus_r;
  mm_req_t               mm_req;
  mm_rsp_t               mm_rsp;

  // Configuration registers; writes to an unused index are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      public_exponent_r  <= '0;
      private_exponent_r <= '0;
      modulus_r          <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PUBLIC_EXP:  public_exponent_r  <= cfg_wdata;
        REG_PRIVATE_EXP: private_exponent_r <= cfg_wdata;
        REG_MODULUS:     modulus_r          <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  rme_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_ch            (in_ch),
    .out_ch           (out_ch),
    .public_exponent  (public_exponent_r),
    .private_exponent (private_exponent_r),
    .modulus          (modulus_r),
    .mm_req           (mm_req),
    .mm_rsp           (mm_rsp)
  );

  rme_modmul u_modmul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mm_req),
    .rsp   (mm_rsp)
  );

endmodule

FILE: test/tb_rsa_modular_exponentiation_top.sv
// Self-checking testbench for the modular exponentiation block: directed table, then random phases.
// Depends on rme_pkg, rme_in_if, rme_out_if and rsa_modular_exponentiation_top from rtl/.
// Each result word is checked against a hand-typed value or a power-mod of the mirrored keys.
module tb_rsa_modular_exponentiation_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rme_pkg::*;

  // Index 3 is decoded by nobody; writes to it must leave the keys alone.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  localparam int NUM_PHASES      = 9;
  localparam int WORDS_PER_PHASE = 30;
  localparam int HOLD_PHASE      = 2;
  localparam int DRAIN_CYCLES    = 10;
  localparam int END_CYCLES      = 100;
  // This leaves a wide margin over the worst-case run time of ~300 words.
  localparam int CYCLE_LIMIT     = 4_000_000;

  typedef enum logic {ROW_REG, ROW_WORD} row_kind_t;

  // One directed step: a key register write, or a word with an optional hand-typed result.
  typedef struct packed {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] idx;
    word_t                data;
    logic                 cmd;
    logic                 known;
    word_t                want;
  } row_t;

  localparam int NUM_ROWS = 30;

  // Register index is ignored on word rows; data is the message there.
  localparam row_t DIRECTED [NUM_ROWS] = '{
    // Reset values: zero modulus forces zero.
    '{ROW_WORD, REG_PUBLIC_EXP,  32'd5,          CMD_ENCRYPT, 1'b1, 32'd0},
    '{ROW_WORD, REG_PUBLIC_EXP,  32'hFFFF_FFFF,  CMD_DECRYPT, 1'b1, 32'd0},
    // Largest modulus with both exponents still zero.
    '{ROW_REG,  REG_MODULUS,     32'hFFFF_FFFF,  CMD_ENCRYPT, 1'b0, 32'd0},
    '{ROW_WORD, REG_PUBLIC_EXP,  32'd0,          CMD_ENCRYPT, 1'b1, 32'd0},
    '{ROW_WORD, REG_PUBLIC_EXP,  32'd7,          CMD_ENCRYPT, 1'b1, 32'd1},
    '{ROW_WORD, REG_PUBLIC_EXP,  32'hFFFF_FFFF,  CMD_DECRYPT, 1'b1, 32'd1},
    // Modulus of one gives zero even for a zero exponent.
    '{ROW_REG,  REG_MODULUS,     32'd1,          CMD_ENCRYPT, 1'b0, 32'd0},
    '{ROW_WORD, REG_PUBLIC_EXP,  32'd12345,      CMD_ENCRYPT, 1'b1, 32'd0},
    // Full-length public exponent, unit private exponent, prime modulus.
    '{ROW_REG,  REG_PUBLIC_EXP,  32'hFFFF_FFFF,  CMD_ENCRYPT, 1'b0, 32'd0},
    '{ROW_REG,  REG_PRIVATE_EXP, 32'd1,          CMD_ENCRYPT, 1'b0, 32'd0},
    '{ROW_REG,  REG_MODULUS,     32'hFFFF_FFFB,  CMD_ENCRYPT, 1'b0, 32'd0},
    '{ROW_WORD, REG_PUBLIC_EXP,  32'hFFFF_FFFF,  CMD_DECRYPT, 1'b1, 32'd4},
    '{ROW_WORD, REG_PUBLIC_EXP,  32'hFFFF_FFFF,  CMD_ENCRYPT, 1'b0, 32'd0},
    '{ROW_WORD, REG_PUBLIC_EXP,  32'hFFFF_FFFB,  CMD_ENCRYPT, 1'b1, 32'd0},
    '{ROW_WORD, REG_PUBLIC_EXP,  32'd1,          CMD_ENCRYPT, 1'b1, 32'd1},
    '{ROW_WORD, REG_PUBLIC_EXP,  32'd2,          CMD_ENCRYPT, 1'b0, 32'd0},
    '{ROW_REG,  REG_UNUSED,      32'hDEAD_BEEF,  CMD_ENCRYPT, 1'b0, 32'd0},
    '{ROW_WORD, REG_PUBLIC_EXP,  32'h1234_5678,  CMD_DECRYPT, 1'b1, 32'h1234_5678},
    // Common public exponent and a single-bit private exponent.
    '{ROW_REG,  REG_PUBLIC_EXP,  32'd65537,      CMD_ENCRYPT, 1'b0, 32'd0},
    '{ROW_REG,  REG_PRIVATE_EXP, 32'h8000_0000,  CMD_ENCRYPT, 1'b0, 32'd0},
    '{ROW_REG,  REG_MODULUS,     32'h8000_0001,  CMD_ENCRYPT, 1'b0, 32'd0},
    '{ROW_WORD, REG_PUBLIC_EXP,  32'h8000_0000,  CMD_ENCRYPT, 1'b0, 32'd0},
    '{ROW_WORD, REG_PUBLIC_EXP,  32'hAAAA_AAAA,  CMD_DECRYPT, 1'b0, 32'd0},
    '{ROW_WORD, REG_PUBLIC_EXP,  32'h5555_5555,  CMD_DECRYPT, 1'b0, 32'd0},
    '{ROW_WORD, REG_PUBLIC_EXP,  32'd3,          CMD_ENCRYPT, 1'b0, 32'd0},
    // Modulus two: odd bases give one, zero base gives zero.
    '{ROW_REG,  REG_MODULUS,     32'd2,          CMD_ENCRYPT, 1'b0, 32'd0},
    '{ROW_WORD, REG_PUBLIC_EXP,  32'd3,          CMD_ENCRYPT, 1'b1, 32'd1},
    '{ROW_WORD, REG_PUBLIC_EXP,  32'd0,          CMD_DECRYPT, 1'b1, 32'd0},
    '{ROW_REG,  REG_PUBLIC_EXP,  32'd0,          CMD_ENCRYPT, 1'b0, 32'd0},
    '{ROW_WORD, REG_PUBLIC_EXP,  32'd3,          CMD_ENCRYPT, 1'b1, 32'd1}
  };

  logic clk;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  rme_in_if  in_ch();
  rme_out_if out_ch();

  rsa_modular_exponentiation_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Mirror of the key registers as the block should hold them.
  word_t pub_exp = '0;
  word_t priv_exp = '0;
  word_t mod_n = '0;

  // Results owed by the block, oldest first.
  word_t pending_powers [$];
  int    error_count = 0;
  bit    src_idle_en = 1'b1;
  bit    sink_idle_en = 1'b1;

  // Clock: 10 ns period.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Right-to-left square-and-multiply with exact double-width products.
  function automatic word_t mod_power(word_t base, word_t expo, word_t n);
    logic [2*WORD_BITS-1:0] acc;
    logic [2*WORD_BITS-1:0] sq;
    logic [2*WORD_BITS-1:0] n_wide;
    if (base == '0 || n == '0) return '0;
    n_wide = n;
    acc = 1 % n_wide;
    sq = base % n_wide;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (expo[i]) acc = (acc * sq) % n_wide;
      sq = (sq * sq) % n_wide;
    end
    return acc[WORD_BITS-1:0];
  endfunction

  function automatic word_t pick_exponent();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 32'd1;
      2: return 32'd3;
      3: return 32'd65537;
      4: return $urandom_range(0, 255);
      7: return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  function automatic word_t pick_modulus();
    case ($urandom_range(0, 11))
      0: return '0;
      1: return 32'd1;
      2: return 32'hFFFF_FFFF;
      3: return 32'h8000_0000;
      4, 5: return $urandom_range(2, 1000);
      default: return $urandom();
    endcase
  endfunction

  // Messages cluster around the modulus so that reduction edges are hit often.
  function automatic word_t pick_message(word_t n);
    case ($urandom_range(0, 11))
      0: return '0;
      1: return 32'd1;
      2: return n - 1;
      3: return n;
      4: return 32'hFFFF_FFFF;
      5: return $urandom_range(0, 255);
      default: return $urandom();
    endcase
  endfunction

  // One register write; the enable is dropped again before the task returns.
  task automatic write_key_reg(input logic [CFG_IDX_W-1:0] idx, input word_t value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_PUBLIC_EXP:  pub_exp = value;
      REG_PRIVATE_EXP: priv_exp = value;
      REG_MODULUS:     mod_n = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Drop valid and hold off until every owed result has come back.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_powers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Offer one word, possibly after an idle burst, and record what it must produce.
  task automatic send_word(input logic cmd, input word_t msg, input logic known,
                           input word_t want);
    int gap;
    gap = 0;
    if (src_idle_en && $urandom_range(0, 99) < 25) gap = $urandom_range(1, 5);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.command <= cmd;
    in_ch.message <= msg;
    do @(posedge clk); while (!in_ch.ready);
    if (known) begin
      pending_powers.push_back(want);
    end else begin
      pending_powers.push_back(mod_power(msg, (cmd == CMD_DECRYPT) ? priv_exp : pub_exp, mod_n));
    end
  endtask

  // Result side: check each accepted word, then decide ready for the next edge.
  initial begin
    int    stall_left;
    word_t want;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (pending_powers.size() == 0) begin
          $display("%0t: unexpected result word: expected none, actual %h", $time, out_ch.result);
          error_count++;
        end else begin
          want = pending_powers.pop_front();
          if (out_ch.result !== want) begin
            $display("%0t: result mismatch: expected %h, actual %h", $time, want, out_ch.result);
            error_count++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (sink_idle_en && $urandom_range(0, 99) < 20) begin
        stall_left = $urandom_range(0, 4);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog on total run length.
  initial begin
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: cycle limit reached with %0d results owed", $time, pending_powers.size());
    $display("rsa_modular_exponentiation_top regression: fail");
    $finish;
  end

  // Stimulus: reset, directed table, random key phases, then drain and report.
  initial begin
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= REG_PUBLIC_EXP;
    cfg_wdata     <= '0;
    in_ch.valid   <= 1'b0;
    in_ch.command <= CMD_ENCRYPT;
    in_ch.message <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table; keys change only once the block has gone quiet.
    foreach (DIRECTED[r]) begin
      if (DIRECTED[r].kind == ROW_REG) begin
        wait_drained();
        write_key_reg(DIRECTED[r].idx, DIRECTED[r].data);
      end else begin
        send_word(DIRECTED[r].cmd, DIRECTED[r].data, DIRECTED[r].known, DIRECTED[r].want);
      end
    end

    // Random phases, each under a fresh key set; the first uses all-ones keys.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_drained();
      src_idle_en  = (ph < NUM_PHASES - 2) && (ph % 4 != 1);
      sink_idle_en = (ph < NUM_PHASES - 2) && (ph % 4 != 3);
      if (ph == 0) begin
        write_key_reg(REG_PUBLIC_EXP, 32'hFFFF_FFFF);
        write_key_reg(REG_PRIVATE_EXP, 32'hFFFF_FFFF);
        write_key_reg(REG_MODULUS, 32'hFFFF_FFFF);
      end else begin
        write_key_reg(REG_PUBLIC_EXP, pick_exponent());
        write_key_reg(REG_PRIVATE_EXP, pick_exponent());
        write_key_reg(REG_MODULUS, pick_modulus());
        if ($urandom_range(0, 3) == 0) write_key_reg(REG_UNUSED, $urandom());
      end
      for (int k = 0; k < WORDS_PER_PHASE; k++) begin
        // Once, the sender waits mid-phase for the block to empty out.
        if (ph == HOLD_PHASE && k == WORDS_PER_PHASE / 2) wait_drained();
        send_word(1'($urandom_range(0, 1)), pick_message(mod_n), 1'b0, '0);
      end
    end

    wait_drained();
    repeat (END_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("rsa_modular_exponentiation_top regression: pass");
    end else begin
      $display("rsa_modular_exponentiation_top regression: fail");
    end
    $finish;
  end

endmodule

FILE: rsa_modular_exponentiation_top.f
rtl/rme_pkg.sv
rtl/rme_in_if.sv
rtl/rme_out_if.sv
rtl/rme_modmul.sv
rtl/rme_ctrl.sv
rtl/rsa_modular_exponentiation_top.sv
test/tb_rsa_modular_exponentiation_top.sv
